>>> rtl/vfc_pkg.sv
// Package for the voxel face culler: command, direction and state codes,
// the item, face and controller/datapath interface structs.
// No dependencies; every other file takes names from here by scope.
package vfc_pkg;

  localparam int unsigned CoordW = 4;
  localparam int unsigned KindW  = 8;
  localparam int unsigned DirW   = 3;

  localparam int unsigned STdataW = 24;
  localparam int unsigned STuserW = 2;
  localparam int unsigned MTdataW = 24;

  localparam logic [KindW-1:0] KIND_AIR   = 8'd0;
  localparam logic [KindW-1:0] KIND_WATER = 8'd1;

  typedef enum logic [1:0] {
    CMD_WR_CHUNK = 2'd0,
    CMD_WR_BND   = 2'd1,
    CMD_MESH     = 2'd2
  } cmd_e;

  typedef enum logic [DirW-1:0] {
    DIR_YP = 3'd0,
    DIR_YN = 3'd1,
    DIR_XP = 3'd2,
    DIR_XN = 3'd3,
    DIR_ZP = 3'd4,
    DIR_ZN = 3'd5
  } dir_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SELF,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [DirW-1:0]   side;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] pos_z;
    logic [KindW-1:0]  block_kind;
  } item_t;

  typedef struct packed {
    logic [CoordW-1:0] face_x;
    logic [CoordW-1:0] face_y;
    logic [CoordW-1:0] face_z;
    logic [DirW-1:0]   face_dir;
    logic              water_mesh;
    logic [KindW-1:0]  face_kind;
    logic              last_face;
  } face_t;

  // controller -> datapath
  typedef struct packed {
    logic            capture;
    logic            latch_self;
    logic [DirW-1:0] nb_dir;
    logic            nb_eval;
    logic [DirW-1:0] eval_dir;
    logic            emit;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mesh_go;
    logic self_air;
    logic any_face;
    logic out_free;
    logic last_face;
  } dp_sts_t;

endpackage

>>> rtl/vfc_datapath.sv
// Datapath of the voxel face culler: chunk and boundary stores, neighbour
// addressing, visibility mask and output register. Depends on vfc_pkg.
module vfc_datapath #(
  parameter int unsigned CHUNK_EDGE = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vfc_pkg::item_t     item_i,
  input  vfc_pkg::ctrl_cmd_t cmd_i,
  input  logic               out_ready_i,
  output vfc_pkg::dp_sts_t   sts_o,
  output logic               out_valid_o,
  output vfc_pkg::face_t     face_o
);

  localparam int unsigned CW          = $clog2(CHUNK_EDGE);
  localparam int unsigned ChunkAddrW  = 3 * CW;
  localparam int unsigned BndAddrW    = vfc_pkg::DirW + 2 * CW;
  localparam int unsigned ChunkDepth  = 1 << ChunkAddrW;
  localparam int unsigned BndDepth    = 1 << BndAddrW;
  localparam logic [CW-1:0] CoordTop  = CW'(CHUNK_EDGE - 1);

  typedef logic [CW-1:0] coord_t;

  logic [vfc_pkg::KindW-1:0] chunk_mem [ChunkDepth];
  logic [vfc_pkg::KindW-1:0] bnd_mem   [BndDepth];

  logic [vfc_pkg::KindW-1:0] chunk_rd_q, bnd_rd_q;
  logic                      sel_bnd_q;

  logic [vfc_pkg::CoordW-1:0] px_q, py_q, pz_q;
  logic [vfc_pkg::KindW-1:0]  kind_q;
  logic                       water_q;
  logic [5:0]                 mask_q, mask_d;

  logic                       out_valid_q, out_valid_d;
  vfc_pkg::face_t             face_q, face_d;

  // input decode
  logic   in_x_ok, in_y_ok, in_z_ok, in_all_ok;
  coord_t in_x, in_y, in_z;
  logic   bnd_ok;
  logic [vfc_pkg::CoordW-1:0] bnd_u4, bnd_v4;
  logic [ChunkAddrW-1:0] chunk_wr_addr;
  logic [BndAddrW-1:0]   bnd_wr_addr;

  always_comb begin
    in_x_ok   = (32'(item_i.pos_x) < CHUNK_EDGE);
    in_y_ok   = (32'(item_i.pos_y) < CHUNK_EDGE);
    in_z_ok   = (32'(item_i.pos_z) < CHUNK_EDGE);
    in_all_ok = in_x_ok && in_y_ok && in_z_ok;
    in_x      = coord_t'(item_i.pos_x);
    in_y      = coord_t'(item_i.pos_y);
    in_z      = coord_t'(item_i.pos_z);
    chunk_wr_addr = {in_z, in_y, in_x};

    bnd_ok = 1'b1;
    bnd_u4 = item_i.pos_x;
    bnd_v4 = item_i.pos_z;
    unique case (item_i.side) inside
      vfc_pkg::DIR_YP, vfc_pkg::DIR_YN: begin
        bnd_u4 = item_i.pos_x;
        bnd_v4 = item_i.pos_z;
      end
      vfc_pkg::DIR_XP, vfc_pkg::DIR_XN: begin
        bnd_u4 = item_i.pos_y;
        bnd_v4 = item_i.pos_z;
      end
      vfc_pkg::DIR_ZP, vfc_pkg::DIR_ZN: begin
        bnd_u4 = item_i.pos_x;
        bnd_v4 = item_i.pos_y;
      end
      default: bnd_ok = 1'b0;
    endcase
    bnd_ok = bnd_ok && (32'(bnd_u4) < CHUNK_EDGE) && (32'(bnd_v4) < CHUNK_EDGE);
    bnd_wr_addr = {item_i.side, coord_t'(bnd_v4), coord_t'(bnd_u4)};
  end

  // neighbour addressing
  coord_t x_c, y_c, z_c, xp_c, xn_c, yp_c, yn_c, zp_c, zn_c;
  logic   nb_edge_c;
  logic [ChunkAddrW-1:0] nb_chunk_addr, chunk_rd_addr;
  logic [BndAddrW-1:0]   bnd_rd_addr;

  always_comb begin
    x_c  = coord_t'(px_q);
    y_c  = coord_t'(py_q);
    z_c  = coord_t'(pz_q);
    xp_c = x_c + coord_t'(1);
    xn_c = x_c - coord_t'(1);
    yp_c = y_c + coord_t'(1);
    yn_c = y_c - coord_t'(1);
    zp_c = z_c + coord_t'(1);
    zn_c = z_c - coord_t'(1);

    nb_edge_c     = 1'b0;
    nb_chunk_addr = {z_c, y_c, x_c};
    bnd_rd_addr   = {vfc_pkg::DIR_YP, z_c, x_c};
    unique case (cmd_i.nb_dir)
      vfc_pkg::DIR_YP: begin
        nb_edge_c     = (y_c == CoordTop);
        nb_chunk_addr = {z_c, yp_c, x_c};
        bnd_rd_addr   = {vfc_pkg::DIR_YP, z_c, x_c};
      end
      vfc_pkg::DIR_YN: begin
        nb_edge_c     = (y_c == '0);
        nb_chunk_addr = {z_c, yn_c, x_c};
        bnd_rd_addr   = {vfc_pkg::DIR_YN, z_c, x_c};
      end
      vfc_pkg::DIR_XP: begin
        nb_edge_c     = (x_c == CoordTop);
        nb_chunk_addr = {z_c, y_c, xp_c};
        bnd_rd_addr   = {vfc_pkg::DIR_XP, z_c, y_c};
      end
      vfc_pkg::DIR_XN: begin
        nb_edge_c     = (x_c == '0);
        nb_chunk_addr = {z_c, y_c, xn_c};
        bnd_rd_addr   = {vfc_pkg::DIR_XN, z_c, y_c};
      end
      vfc_pkg::DIR_ZP: begin
        nb_edge_c     = (z_c == CoordTop);
        nb_chunk_addr = {zp_c, y_c, x_c};
        bnd_rd_addr   = {vfc_pkg::DIR_ZP, y_c, x_c};
      end
      vfc_pkg::DIR_ZN: begin
        nb_edge_c     = (z_c == '0);
        nb_chunk_addr = {zn_c, y_c, x_c};
        bnd_rd_addr   = {vfc_pkg::DIR_ZN, y_c, x_c};
      end
      default: nb_edge_c = 1'b0;
    endcase

    // the self read is issued in the accept cycle straight from the beat
    chunk_rd_addr = cmd_i.capture ? chunk_wr_addr : nb_chunk_addr;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && (item_i.command == vfc_pkg::CMD_WR_CHUNK) && in_all_ok) begin
      chunk_mem[chunk_wr_addr] <= item_i.block_kind;
    end
    chunk_rd_q <= chunk_mem[chunk_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && (item_i.command == vfc_pkg::CMD_WR_BND) && bnd_ok) begin
      bnd_mem[bnd_wr_addr] <= item_i.block_kind;
    end
    bnd_rd_q <= bnd_mem[bnd_rd_addr];
  end

  // visibility and face selection
  logic [vfc_pkg::KindW-1:0] nb_kind;
  logic                      shown_c;
  logic [5:0]                mask_rest;
  logic [vfc_pkg::DirW-1:0]  low_idx;

  always_comb begin
    nb_kind = sel_bnd_q ? bnd_rd_q : chunk_rd_q;
    shown_c = water_q ? (nb_kind == vfc_pkg::KIND_AIR)
                      : ((nb_kind == vfc_pkg::KIND_AIR) || (nb_kind == vfc_pkg::KIND_WATER));
    mask_rest = mask_q & (mask_q - 6'd1);
    low_idx   = '0;
    for (int i = 5; i >= 0; i--) begin
      if (mask_q[i]) begin
        low_idx = vfc_pkg::DirW'(i);
      end
    end

    mask_d = mask_q;
    if (cmd_i.latch_self) begin
      mask_d = '0;
    end else if (cmd_i.nb_eval) begin
      mask_d[cmd_i.eval_dir] = shown_c;
    end else if (cmd_i.emit) begin
      mask_d = mask_rest;
    end

    face_d      = face_q;
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      face_d.face_x     = px_q;
      face_d.face_y     = py_q;
      face_d.face_z     = pz_q;
      face_d.face_dir   = low_idx;
      face_d.water_mesh = water_q;
      face_d.face_kind  = kind_q;
      face_d.last_face  = (mask_rest == '0);
      out_valid_d       = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_bnd_q <= nb_edge_c;
    face_q    <= face_d;
    if (cmd_i.capture) begin
      px_q <= item_i.pos_x;
      py_q <= item_i.pos_y;
      pz_q <= item_i.pos_z;
    end
    if (cmd_i.latch_self) begin
      kind_q  <= chunk_rd_q;
      water_q <= (chunk_rd_q == vfc_pkg::KIND_WATER);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.mesh_go   = (item_i.command == vfc_pkg::CMD_MESH) && in_all_ok;
  assign sts_o.self_air  = (chunk_rd_q == vfc_pkg::KIND_AIR);
  assign sts_o.any_face  = (mask_q != '0) || shown_c;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.last_face = (mask_rest == '0);

  assign out_valid_o = out_valid_q;
  assign face_o      = face_q;

endmodule

>>> rtl/vfc_ctrl.sv
// Controller of the voxel face culler: state machine that sequences the
// self read, six neighbour reads and face emission. Depends on vfc_pkg.
module vfc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vfc_pkg::dp_sts_t   sts_i,
  output vfc_pkg::ctrl_cmd_t cmd_o
);

  vfc_pkg::state_e          state_q, state_d;
  logic [vfc_pkg::DirW-1:0] dir_cnt_q, dir_cnt_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vfc_pkg::ST_IDLE: begin
        if (in_valid_i && sts_i.mesh_go) begin
          state_d = vfc_pkg::ST_SELF;
        end
      end
      vfc_pkg::ST_SELF: begin
        state_d = sts_i.self_air ? vfc_pkg::ST_IDLE : vfc_pkg::ST_SCAN;
      end
      vfc_pkg::ST_SCAN: begin
        if (dir_cnt_q == vfc_pkg::DIR_ZN) begin
          state_d = sts_i.any_face ? vfc_pkg::ST_EMIT : vfc_pkg::ST_IDLE;
        end
      end
      vfc_pkg::ST_EMIT: begin
        if (sts_i.out_free && sts_i.last_face) begin
          state_d = vfc_pkg::ST_IDLE;
        end
      end
      default: state_d = vfc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    dir_cnt_d  = dir_cnt_q;
    unique case (state_q)
      vfc_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      vfc_pkg::ST_SELF: begin
        cmd_o.latch_self = 1'b1;
        cmd_o.nb_dir     = vfc_pkg::DIR_YP;
        dir_cnt_d        = vfc_pkg::DIR_YP;
      end
      vfc_pkg::ST_SCAN: begin
        cmd_o.nb_eval  = 1'b1;
        cmd_o.eval_dir = dir_cnt_q;
        cmd_o.nb_dir   = dir_cnt_q + 3'd1;
        dir_cnt_d      = dir_cnt_q + 3'd1;
      end
      vfc_pkg::ST_EMIT: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= vfc_pkg::ST_IDLE;
      dir_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      dir_cnt_q <= dir_cnt_d;
    end
  end

endmodule

>>> rtl/voxel_face_culler_top.sv
// Top level of the voxel face culler: stream ports, beat packing and the
// controller and datapath instances. Depends on vfc_pkg, vfc_ctrl, vfc_datapath.
//
//  channel   dir  handshake               tdata / tuser / tlast
//  s_axis    in   s_axis_tvalid/tready    tdata: side, pos_x, pos_y, pos_z, block_kind
//                                         tuser: command
//  m_axis    out  m_axis_tvalid/tready    tdata: face_x, face_y, face_z, face_dir, face_kind
//                                         tuser: water_mesh   tlast: last_face
//
// A write beat (chunk or boundary) goes straight into its store. A mesh beat
// does the self read, then, unless the voxel is air, one neighbour read per
// cycle, set by the single read port of each store, then emits each visible
// face in turn as the output register frees.
// Reset clears the controller, the face mask and the output valid; store
// contents are undefined until written. A stalled last face holds in the
// output register while the next beat is already taken in.
module voxel_face_culler_top #(
  parameter int unsigned CHUNK_EDGE = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [2:0] side, [6:3] pos_x, [10:7] pos_y, [14:11] pos_z, [22:15] block_kind
  input  logic [vfc_pkg::STdataW-1:0]  s_axis_tdata,
  // [1:0] command
  input  logic [vfc_pkg::STuserW-1:0]  s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [3:0] face_x, [7:4] face_y, [11:8] face_z, [14:12] face_dir, [22:15] face_kind
  output logic [vfc_pkg::MTdataW-1:0]  m_axis_tdata,
  // [0] water_mesh
  output logic                         m_axis_tuser,
  output logic                         m_axis_tlast
);

  vfc_pkg::item_t     item;
  vfc_pkg::face_t     face;
  vfc_pkg::ctrl_cmd_t cmd;
  vfc_pkg::dp_sts_t   sts;

  // unpack the beat into item fields; the top bit of tdata is padding
  assign item.command    = s_axis_tuser;
  assign item.side       = s_axis_tdata[2:0];
  assign item.pos_x      = s_axis_tdata[6:3];
  assign item.pos_y      = s_axis_tdata[10:7];
  assign item.pos_z      = s_axis_tdata[14:11];
  assign item.block_kind = s_axis_tdata[22:15];

  vfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vfc_datapath #(
    .CHUNK_EDGE (CHUNK_EDGE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .cmd_i       (cmd),
    .out_ready_i (m_axis_tready),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .face_o      (face)
  );

  // pack the face; pad the top bit of tdata with zero
  assign m_axis_tdata = {1'b0, face.face_kind, face.face_dir,
                         face.face_z, face.face_y, face.face_x};
  assign m_axis_tuser = face.water_mesh;
  assign m_axis_tlast = face.last_face;

endmodule

>>> rtl/vfc_checker.sv
// Port-level checker for the voxel face culler, bound to the top level.
// Depends on vfc_pkg.
module vfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // hold a stalled face beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("face beat changed while stalled");

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[14:12] != 3'd6) && (m_axis_tdata[14:12] != 3'd7))
    else $error("face direction out of range");

  a_water_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[22:15] == vfc_pkg::KIND_WATER)
    else $error("water mesh face from a non-water voxel");

  a_solid_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      (m_axis_tdata[22:15] != vfc_pkg::KIND_AIR)
      && (m_axis_tdata[22:15] != vfc_pkg::KIND_WATER))
    else $error("solid mesh face from air or water");

endmodule

bind voxel_face_culler_top vfc_checker u_vfc_checker (.*);
